### src/kli_pkg.sv
// Package for the keyframe linear interpolator: opcodes, widths, queue word.
// No dependencies.
`default_nettype none
package kli_pkg;
  localparam int MAX_KEYS_DEF = 16;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    OP_WRITE_KEY = 2'd0,
    OP_WRITE_VALUE = 2'd1,
    OP_INTERP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] CFG_KEY_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;

  // word passed from the front end to the back end
  typedef struct packed {
    op_t op;
    logic [3:0] entry_index;
    logic [1:0] channel_index;
    logic [16:0] fraction_word;
    logic [31:0] value_word;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_KEY1, ST_KEY2, ST_ROW, ST_VAL1, ST_VAL2,
    ST_MUL, ST_START, ST_DIV, ST_SUM, ST_OUT
  } state_t;
endpackage
`default_nettype wire

### src/kli_front.sv
// Front end: accepts items, drops no-ops, feeds a two-entry queue.
// Depends on kli_pkg.
`default_nettype none
module kli_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               valid,
  output logic              ready,
  input  wire         [1:0] op,
  input  wire         [3:0] entry_index,
  input  wire         [1:0] channel_index,
  input  wire        [16:0] fraction_word,
  input  wire signed [31:0] value_word,
  output logic              q_valid,
  input  wire               q_ready,
  output kli_pkg::cmd_t     q_word
);
  import kli_pkg::*;
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign ready = (count != 2'd2);
  assign push = valid && ready && (op != OP_NONE);
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_word = mem[rp];

  // hold queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{op_t'(op), entry_index, channel_index, fraction_word, value_word};
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### src/kli_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module kli_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [48:0] dividend,
  input  wire  [16:0] divisor,
  output logic        done,
  output logic [48:0] quotient
);
  logic [5:0] cnt;
  logic busy;
  logic [17:0] rem;
  logic [17:0] trial;

  assign trial = {rem[16:0], quotient[48]} - {1'b0, divisor};

  // step one bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 18'd0;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial;
        quotient <= {quotient[47:0], 1'b1};
      end else begin
        rem <= {rem[16:0], quotient[48]};
        quotient <= {quotient[47:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### src/kli_back.sv
// Back end: table writes, key search, per-channel blend and output register.
// Depends on kli_pkg and kli_div.
`default_nettype none
module kli_back #(
  parameter int MAX_KEYS = 16,
  parameter int MAX_CHANNELS = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  output logic               q_ready,
  input  kli_pkg::cmd_t      q_word,
  input  wire          [4:0] key_count,
  input  wire          [2:0] channel_count,
  output logic               out_valid,
  input  wire                out_ready,
  output logic         [1:0] out_channel,
  output logic signed [31:0] out_value,
  output logic               last
);
  import kli_pkg::*;
  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW = KW + CW;

  logic [16:0] key_mem [MAX_KEYS];
  logic [31:0] val_mem [1 << AW];

  state_t state, state_next;
  cmd_t cmd;
  logic [8:0] n, pos;
  logic [4:0] nch, ch;
  logic [16:0] key_rd, k1, k2;
  logic [31:0] val_rd;
  logic signed [32:0] v1, diff;
  logic [KW-1:0] row1, row2;
  logic [KW-1:0] key_addr;
  logic [AW-1:0] val_addr;
  logic signed [17:0] fk;
  logic signed [51:0] prod;
  logic neg;
  logic [48:0] mag, quot;
  logic signed [17:0] den_s;
  logic [16:0] den;
  logic div_start, div_done;
  logic signed [50:0] sum;
  logic load_cmd;
  logic search_hit;
  logic state_flag_hit;
  logic [16:0] key_hi;
  logic [31:0] val_lo;

  function automatic logic cmd_ok_key(cmd_t w);
    return (w.op == OP_WRITE_KEY) && ({5'd0, w.entry_index} < 9'(MAX_KEYS));
  endfunction
  function automatic logic cmd_ok_val(cmd_t w);
    return (w.op == OP_WRITE_VALUE) && ({5'd0, w.entry_index} < 9'(MAX_KEYS))
           && ({3'd0, w.channel_index} < 5'(MAX_CHANNELS));
  endfunction

  // clamp counts
  always_comb begin
    n = ({4'd0, key_count} > 9'(MAX_KEYS)) ? 9'(MAX_KEYS) : {4'd0, key_count};
    nch = ({2'd0, channel_count} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS)
          : {2'd0, channel_count};
  end

  assign q_ready = (state == ST_IDLE);
  assign load_cmd = q_valid && q_ready;

  // signed key span and its magnitude
  assign den_s = $signed({1'b0, k2}) - $signed({1'b0, k1});
  assign den = den_s[17] ? 17'(-den_s) : den_s[16:0];

  // key_rd holds key[pos-1] once pos is nonzero
  assign search_hit = (state == ST_SEARCH) && (pos != 9'd0)
                      && (key_rd > cmd.fraction_word || key_rd >= ONE_Q16);

  // table address mux
  always_comb begin
    key_addr = pos[KW-1:0];
    if (state == ST_KEY1) key_addr = row1;
    val_addr = {row1, ch[CW-1:0]};
    if (state == ST_VAL1) val_addr = {row2, ch[CW-1:0]};
  end

  // write tables, registered reads
  always_ff @(posedge clk) begin
    if (load_cmd && cmd_ok_key(q_word)) key_mem[KW'(q_word.entry_index)] <= q_word.fraction_word;
    if (load_cmd && cmd_ok_val(q_word))
      val_mem[{KW'(q_word.entry_index), CW'(q_word.channel_index)}] <= q_word.value_word;
    key_rd <= key_mem[key_addr];
    val_rd <= val_mem[val_addr];
  end

  kli_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mag),
    .divisor(den), .done(div_done), .quotient(quot)
  );

  // next state
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE: if (load_cmd && q_word.op == OP_INTERP) state_next = ST_SEARCH;
      ST_SEARCH: if (search_hit || pos == n) state_next = ST_KEY1;
      ST_KEY1: state_next = ST_KEY2;
      ST_KEY2: state_next = (nch == 5'd0) ? ST_IDLE : ST_ROW;
      ST_ROW: state_next = ST_VAL1;
      ST_VAL1: state_next = ST_VAL2;
      ST_VAL2: state_next = ST_MUL;
      ST_MUL: state_next = (k1 == k2 || n == 9'd0) ? ST_SUM : ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: if (div_done) state_next = ST_SUM;
      ST_SUM: state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = (ch + 5'd1 == nch) ? ST_IDLE : ST_ROW;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= q_word;
        pos <= 9'd0;
        ch <= 5'd0;
      end
      ST_SEARCH: begin
        // one key per cycle; on a hit pos steps back to the hit index
        if (search_hit) begin
          pos <= pos - 9'd1;
          row1 <= (pos > 9'd1) ? KW'(pos - 9'd2) : '0;
          row2 <= KW'(pos - 9'd1);
          state_flag_hit <= 1'b1;
        end else if (pos == n) begin
          row1 <= (n != 9'd0) ? KW'(n - 9'd1) : '0;
          row2 <= (n != 9'd0) ? KW'(n - 9'd1) : '0;
          state_flag_hit <= 1'b0;
        end else begin
          pos <= pos + 9'd1;
        end
      end
      ST_KEY1: ; // key read of row1 issued
      ST_KEY2: begin
        k1 <= (pos == 9'd0) ? 17'd0 : key_rd;
        k2 <= state_flag_hit ? key_hi : ONE_Q16;
        if (pos == 9'd0) row1 <= '0;
      end
      ST_VAL2: begin
        v1 <= {val_lo[31], val_lo};
        diff <= {val_rd[31], val_rd} - {val_lo[31], val_lo};
        fk <= $signed({1'b0, cmd.fraction_word}) - $signed({1'b0, k1});
      end
      ST_MUL: begin
        prod <= 52'(diff * fk);
      end
      ST_DIV: ;
      ST_SUM: begin
        if (k1 == k2) sum <= 51'(v1);
        else if (neg) sum <= 51'(v1) - $signed({2'b0, quot});
        else sum <= 51'(v1) + $signed({2'b0, quot});
      end
      ST_OUT: if (!out_valid || out_ready) ch <= ch + 5'd1;
      default: ;
    endcase
  end

  // capture the upper key while searching and the lower row value
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && pos != 9'd0) key_hi <= key_rd;
    if (state == ST_VAL1) val_lo <= val_rd;
  end

  // magnitude with half-divisor rounding; sign from product and key span
  always_comb begin
    neg = prod[51] ^ den_s[17];
    mag = 49'(prod[51] ? -prod : prod) + 49'(den >> 1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_channel <= ch[1:0];
        last <= (ch + 5'd1 == nch);
        if (n == 9'd0) out_value <= '0;
        else if (sum > 51'sd2147483647) out_value <= 32'sh7fffffff;
        else if (sum < -51'sd2147483648) out_value <= 32'sh80000000;
        else out_value <= sum[31:0];
      end
    end
  end
endmodule
`default_nettype wire

### src/keyframe_linear_interpolator_top.sv
// Top level of the keyframe linear interpolator: config registers, front, back.
// Depends on kli_pkg, kli_front, kli_back.
`default_nettype none
// An interpolate item runs a linear key search over n keys (one key table read
// a cycle), then blends each channel through the 49-step bit-serial divider,
// which is skipped when the key span is zero or no keys are set. Results leave through a
// registered output; a two-word queue lets the next item enter meanwhile.
module keyframe_linear_interpolator_top #(
  parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF,
  parameter int MAX_CHANNELS = kli_pkg::MAX_CHANNELS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               valid,
  output logic              ready,
  input  wire         [1:0] op,
  input  wire         [3:0] entry_index,
  input  wire         [1:0] channel_index,
  input  wire        [16:0] fraction_word,
  input  wire signed [31:0] value_word,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire         [1:0] cfg_index,
  input  wire        [31:0] cfg_data,
  output logic              out_valid,
  input  wire               out_ready,
  output logic        [1:0] out_channel,
  output logic signed [31:0] out_value,
  output logic              last
);
  import kli_pkg::*;
  logic [4:0] key_count;
  logic [2:0] channel_count;
  logic q_valid, q_ready;
  cmd_t q_word;

  assign cfg_ready = 1'b1;

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 5'd0;
      channel_count <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_KEY_COUNT) key_count <= cfg_data[4:0];
      else if (cfg_index == CFG_CHANNEL_COUNT) channel_count <= cfg_data[2:0];
    end
  end

  kli_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .op(op),
    .entry_index(entry_index), .channel_index(channel_index),
    .fraction_word(fraction_word), .value_word(value_word),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  kli_back #(.MAX_KEYS(MAX_KEYS), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .key_count(key_count), .channel_count(channel_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .out_value(out_value), .last(last)
  );

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(last))
    else $error("result changed while stalled");
  // channel number is zero after the final channel of a run
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last ##1 out_valid && out_ready |-> out_channel == 2'd0)
    else $error("run did not restart at channel zero");
endmodule
`default_nettype wire
